### hw/rtl/pendulum_arm_euler_step_unit_defines.svh
// assertion macros for the pendulum arm step unit checker
// depends on: a clock named clock and an active-high reset named reset in the using scope
`ifndef PENDULUM_ARM_EULER_STEP_UNIT_DEFINES_SVH
`define PENDULUM_ARM_EULER_STEP_UNIT_DEFINES_SVH

// antecedent in a cycle implies consequent in the same cycle
`define PAE_ASSERT_IMPLY(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pae check failed: same-cycle implication");

// antecedent in a cycle implies consequent in the next cycle
`define PAE_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pae check failed: next-cycle implication");

// condition holds at every clock edge out of reset
`define PAE_ASSERT_ALWAYS(name, cond) \
   name: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("pae check failed: invariant");

`endif

### hw/rtl/pae_pkg.sv
// shared constants, microcode words, sine table and helpers for the pendulum arm step unit
// no dependencies; imported by the top level and the checker
`timescale 1ns / 1ps

package pae_pkg;

   // fixed-point setup (table depth must be a power of two)
   localparam int SINE_TABLE_DEPTH = 1024;
   localparam int FRAC_BITS        = 16;
   localparam int TIME_FRAC        = 16;
   localparam int SIN_IDX_W        = $clog2(SINE_TABLE_DEPTH);
   localparam int SIN_W            = FRAC_BITS + 2;

   // field widths
   localparam int ANGLE_W = 19;
   localparam int DATA_W  = 32;
   localparam int STIME_W = 17;
   localparam int PROD_W  = 64;
   localparam int WIDE_W  = 68;
   localparam int ADDR_W  = 5;
   localparam int UPC_W   = 4;

   // angle constants in Q30 and the turn scale in Q32
   localparam logic [63:0] TWO_PI_Q30  = 64'd6746518852;
   localparam logic [63:0] PI_Q30      = 64'd3373259426;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic signed [DATA_W-1:0] INV_TWO_PI_Q32 = 32'sd683565276;

   // register reset values
   localparam logic signed [DATA_W-1:0]  ARM_GAIN_RST     = 32'sd65536;
   localparam logic signed [DATA_W-1:0]  GRAVITY_GAIN_RST = 32'sd65536;
   localparam logic [STIME_W-1:0]        SAMPLE_TIME_RST  = 17'd655;
   localparam logic signed [ANGLE_W-1:0] MAX_ANGLE_RST    = 19'sd102943;
   localparam logic signed [ANGLE_W-1:0] MIN_ANGLE_RST    = -19'sd102943;

   // register indexes
   localparam logic [2:0] REG_ARM_GAIN     = 3'd0;
   localparam logic [2:0] REG_GRAVITY_GAIN = 3'd1;
   localparam logic [2:0] REG_SAMPLE_TIME  = 3'd2;
   localparam logic [2:0] REG_MAX_ANGLE    = 3'd3;
   localparam logic [2:0] REG_MIN_ANGLE    = 3'd4;

   // request kinds
   localparam logic REQ_STEP = 1'b0;
   localparam logic REQ_SET  = 1'b1;

   // multiplier operand selects
   localparam logic [2:0] MA_ANGLE = 3'd0;
   localparam logic [2:0] MA_ARM   = 3'd1;
   localparam logic [2:0] MA_GRAV  = 3'd2;
   localparam logic [2:0] MA_ACCEL = 3'd3;
   localparam logic [2:0] MA_RATE  = 3'd4;
   localparam logic [1:0] MB_INV    = 2'd0;
   localparam logic [1:0] MB_THRUST = 2'd1;
   localparam logic [1:0] MB_SINE   = 2'd2;
   localparam logic [1:0] MB_STIME  = 2'd3;

   // program addresses
   localparam logic [UPC_W-1:0] UA_TURN    = 4'd0;
   localparam logic [UPC_W-1:0] UA_SINE    = 4'd1;
   localparam logic [UPC_W-1:0] UA_GRAV    = 4'd2;
   localparam logic [UPC_W-1:0] UA_ACCEL   = 4'd3;
   localparam logic [UPC_W-1:0] UA_DVEL    = 4'd4;
   localparam logic [UPC_W-1:0] UA_RATE    = 4'd5;
   localparam logic [UPC_W-1:0] UA_DANG    = 4'd6;
   localparam logic [UPC_W-1:0] UA_ANGLE   = 4'd7;
   localparam logic [UPC_W-1:0] UA_SET     = 4'd8;

   // one control word of the step program
   typedef struct packed {
      logic [2:0]       mul_a;
      logic [1:0]       mul_b;
      logic             mul_en;
      logic             sin_ld;
      logic             acc_ld;
      logic             accel_wr;
      logic             rate_wr;
      logic             fin_step;
      logic             fin_set;
      logic             br_set;
      logic [UPC_W-1:0] br_tgt;
   } uword_type;

   typedef logic signed [SIN_W-1:0] sine_rom_type [SINE_TABLE_DEPTH];

   // microcode store
   function automatic uword_type ucode_word(input logic [UPC_W-1:0] pc);
      uword_type w;
      w = '0;
      case (pc)
         UA_TURN: begin
            w.mul_a  = MA_ANGLE;
            w.mul_b  = MB_INV;
            w.mul_en = 1'b1;
            w.br_set = 1'b1;
            w.br_tgt = UA_SET;
         end
         UA_SINE: begin
            w.sin_ld = 1'b1;
            w.mul_a  = MA_ARM;
            w.mul_b  = MB_THRUST;
            w.mul_en = 1'b1;
         end
         UA_GRAV: begin
            w.acc_ld = 1'b1;
            w.mul_a  = MA_GRAV;
            w.mul_b  = MB_SINE;
            w.mul_en = 1'b1;
         end
         UA_ACCEL: begin
            w.accel_wr = 1'b1;
         end
         UA_DVEL: begin
            w.mul_a  = MA_ACCEL;
            w.mul_b  = MB_STIME;
            w.mul_en = 1'b1;
         end
         UA_RATE: begin
            w.rate_wr = 1'b1;
         end
         UA_DANG: begin
            w.mul_a  = MA_RATE;
            w.mul_b  = MB_STIME;
            w.mul_en = 1'b1;
         end
         UA_ANGLE: begin
            w.fin_step = 1'b1;
         end
         UA_SET: begin
            w.fin_set = 1'b1;
         end
         default: begin
            w = '0;
         end
      endcase
      return w;
   endfunction

   // one sine entry: taylor series to the 13th power over a quarter turn in Q30, rounded to Q16
   function automatic logic signed [SIN_W-1:0] sine_entry(input int unsigned i);
      logic [63:0]        th;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic [63:0]        mag;
      logic [63:0]        res;
      logic signed [63:0] sum;
      logic               neg;
      th  = (TWO_PI_Q30 * 64'(i)) / SINE_TABLE_DEPTH;
      neg = 1'b0;
      if (th >= PI_Q30) begin
         th  = th - PI_Q30;
         neg = 1'b1;
      end
      if (th > HALF_PI_Q30) begin
         th = PI_Q30 - th;
      end
      x2   = (th * th) >> 30;
      term = th;
      sum  = signed'(th);
      term = ((term * x2) >> 30) / 6;
      sum  = sum - signed'(term);
      term = ((term * x2) >> 30) / 20;
      sum  = sum + signed'(term);
      term = ((term * x2) >> 30) / 42;
      sum  = sum - signed'(term);
      term = ((term * x2) >> 30) / 72;
      sum  = sum + signed'(term);
      term = ((term * x2) >> 30) / 110;
      sum  = sum - signed'(term);
      term = ((term * x2) >> 30) / 156;
      sum  = sum + signed'(term);
      if (sum < 0) begin
         sum = '0;
      end
      mag = (unsigned'(sum) + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
      res = neg ? (64'd0 - mag) : mag;
      return signed'(res[SIN_W-1:0]);
   endfunction

   function automatic sine_rom_type build_sine_rom();
      sine_rom_type r;
      for (int unsigned i = 0; i < SINE_TABLE_DEPTH; i++) begin
         r[i] = sine_entry(i);
      end
      return r;
   endfunction

   // sine over one turn, Q(FRAC_BITS)
   localparam sine_rom_type SINE_ROM = build_sine_rom();

   // clamp a wide signed value to the 32-bit range
   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
      logic signed [DATA_W-1:0] r;
      if (v > 68'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -68'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = signed'(v[DATA_W-1:0]);
      end
      return r;
   endfunction

endpackage

### hw/rtl/pendulum_arm_euler_step_unit.sv
// Pendulum arm model for hardware-in-the-loop use: angle in signed Q3.16; rate,
// acceleration and last thrust in signed Q16.16; advanced by forward Euler. A step
// request computes accel = arm_gain*thrust - gravity_gain*sin(angle) (sine from a
// 1024-entry table over one turn), then rate and angle over sample_time, with the angle
// clamped to [min_angle, max_angle] (rate zeroed, at_limit set). A set request
// overwrites the angle. Every request returns one response carrying the full state.
// Sequencing: a step request runs an eight-word microcode program around one shared
// 32x32 multiplier; a set request runs the turn word, which branches to the set word.
// No request is taken while a program runs. A finished response waits in an output
// register while the next request is taken; the program holds on its last word only
// while that register is occupied and rsp_ready is low. Registers sit at byte
// addresses 0x00 arm_gain, 0x04 gravity_gain, 0x08 sample_time, 0x0c max_angle,
// 0x10 min_angle; write them only while the unit is idle.
// depends on: pae_pkg
`timescale 1ns / 1ps

module pendulum_arm_euler_step_unit
   import pae_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_req_type,
   input  logic signed [DATA_W-1:0]  req_thrust,
   input  logic signed [ANGLE_W-1:0] req_angle_value,
   // response channel
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [ANGLE_W-1:0] rsp_angle,
   output logic signed [DATA_W-1:0]  rsp_rate,
   output logic signed [DATA_W-1:0]  rsp_accel,
   output logic signed [DATA_W-1:0]  rsp_last_thrust,
   output logic                      rsp_at_limit,
   // register port
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [ADDR_W-1:0]         paddr,
   input  logic [DATA_W-1:0]         pwdata,
   output logic [DATA_W-1:0]         prdata,
   output logic                      pready
);

   // configuration registers
   logic signed [DATA_W-1:0]  arm_gain_ff;
   logic signed [DATA_W-1:0]  gravity_gain_ff;
   logic [STIME_W-1:0]        sample_time_ff;
   logic signed [ANGLE_W-1:0] max_angle_ff;
   logic signed [ANGLE_W-1:0] min_angle_ff;

   // sequencer
   logic             busy_ff;
   logic [UPC_W-1:0] pc_ff;
   logic [UPC_W-1:0] pc_in;
   uword_type        uw;
   logic             req_xfer;
   logic             fin;
   logic             stall;
   logic             advance;

   // captured request
   logic                      item_type_ff;
   logic signed [DATA_W-1:0]  item_thrust_ff;
   logic signed [ANGLE_W-1:0] item_angle_ff;

   // model state
   logic signed [ANGLE_W-1:0] angle_ff;
   logic signed [DATA_W-1:0]  rate_ff;
   logic signed [DATA_W-1:0]  accel_ff;
   logic signed [DATA_W-1:0]  thrust_ff;

   // datapath
   logic signed [DATA_W-1:0]  mul_a_v;
   logic signed [DATA_W-1:0]  mul_b_v;
   logic signed [PROD_W-1:0]  mul_p;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [PROD_W-1:0]  acc_ff;
   logic signed [SIN_W-1:0]   sin_ff;
   logic [DATA_W-1:0]         turn_frac;
   logic [SIN_IDX_W:0]        idx_sum;
   logic [SIN_IDX_W-1:0]      sin_idx;
   logic signed [PROD_W:0]    accel_diff;
   logic signed [PROD_W:0]    accel_shift;
   logic signed [PROD_W-1:0]  step_delta;
   logic signed [DATA_W-1:0]  accel_in;
   logic signed [DATA_W-1:0]  rate_in;
   logic signed [WIDE_W-1:0]  angle_sum;
   logic signed [ANGLE_W-1:0] angle_in;
   logic                      limit_in;

   // response register
   logic                      rsp_valid_ff;
   logic signed [ANGLE_W-1:0] rsp_angle_ff;
   logic signed [DATA_W-1:0]  rsp_rate_ff;
   logic signed [DATA_W-1:0]  rsp_accel_ff;
   logic signed [DATA_W-1:0]  rsp_last_thrust_ff;
   logic                      rsp_at_limit_ff;

   logic                      csr_wr;

   // register port write and read
   assign csr_wr = psel & penable & pwrite;
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         arm_gain_ff     <= ARM_GAIN_RST;
         gravity_gain_ff <= GRAVITY_GAIN_RST;
         sample_time_ff  <= SAMPLE_TIME_RST;
         max_angle_ff    <= MAX_ANGLE_RST;
         min_angle_ff    <= MIN_ANGLE_RST;
      end else if (csr_wr) begin
         case (paddr[4:2])
            REG_ARM_GAIN:     arm_gain_ff     <= signed'(pwdata);
            REG_GRAVITY_GAIN: gravity_gain_ff <= signed'(pwdata);
            REG_SAMPLE_TIME:  sample_time_ff  <= pwdata[STIME_W-1:0];
            REG_MAX_ANGLE:    max_angle_ff    <= signed'(pwdata[ANGLE_W-1:0]);
            REG_MIN_ANGLE:    min_angle_ff    <= signed'(pwdata[ANGLE_W-1:0]);
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (paddr[4:2])
         REG_ARM_GAIN:     prdata = unsigned'(arm_gain_ff);
         REG_GRAVITY_GAIN: prdata = unsigned'(gravity_gain_ff);
         REG_SAMPLE_TIME:  prdata = DATA_W'(sample_time_ff);
         REG_MAX_ANGLE:    prdata = unsigned'(DATA_W'(max_angle_ff));
         REG_MIN_ANGLE:    prdata = unsigned'(DATA_W'(min_angle_ff));
         default:          prdata = '0;
      endcase
   end

   // sequencer: fetch, hold on the last word while the response register is full and not being read
   assign uw        = ucode_word(pc_ff);
   assign req_ready = ~busy_ff;
   assign req_xfer  = req_valid & req_ready;
   assign fin       = uw.fin_step | uw.fin_set;
   assign stall     = fin & rsp_valid_ff & ~rsp_ready;
   assign advance   = busy_ff & ~stall;

   always_comb begin
      pc_in = pc_ff;
      if (advance) begin
         if (fin) begin
            pc_in = UA_TURN;
         end else if (uw.br_set && (item_type_ff == REQ_SET)) begin
            pc_in = uw.br_tgt;
         end else begin
            pc_in = UPC_W'(pc_ff + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pc_ff   <= UA_TURN;
      end else begin
         pc_ff <= pc_in;
         if (req_xfer) begin
            busy_ff <= 1'b1;
         end else if (advance && fin) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // request capture on transfer
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         item_type_ff   <= req_req_type;
         item_thrust_ff <= req_thrust;
         item_angle_ff  <= req_angle_value;
      end
   end

   // shared multiplier operand select
   always_comb begin
      case (uw.mul_a)
         MA_ANGLE: mul_a_v = DATA_W'(angle_ff);
         MA_ARM:   mul_a_v = arm_gain_ff;
         MA_GRAV:  mul_a_v = gravity_gain_ff;
         MA_ACCEL: mul_a_v = accel_ff;
         MA_RATE:  mul_a_v = rate_ff;
         default:  mul_a_v = '0;
      endcase
      case (uw.mul_b)
         MB_INV:    mul_b_v = INV_TWO_PI_Q32;
         MB_THRUST: mul_b_v = item_thrust_ff;
         MB_SINE:   mul_b_v = DATA_W'(sin_ff);
         MB_STIME:  mul_b_v = signed'(DATA_W'(sample_time_ff));
         default:   mul_b_v = '0;
      endcase
   end

   assign mul_p = PROD_W'(mul_a_v) * PROD_W'(mul_b_v);

   // table index: fraction of a turn, rounded to the nearest entry
   assign turn_frac = prod_ff[FRAC_BITS+DATA_W-1:FRAC_BITS];
   assign idx_sum   = {1'b0, turn_frac[DATA_W-1 -: SIN_IDX_W]}
                      + (SIN_IDX_W+1)'(turn_frac[DATA_W-1-SIN_IDX_W]);
   assign sin_idx   = idx_sum[SIN_IDX_W-1:0];

   // acceleration, rate and angle arithmetic
   assign accel_diff  = (PROD_W+1)'(acc_ff) - (PROD_W+1)'(prod_ff);
   assign accel_shift = accel_diff >>> FRAC_BITS;
   assign accel_in    = sat32(WIDE_W'(accel_shift));
   assign step_delta  = prod_ff >>> TIME_FRAC;
   assign rate_in     = sat32(WIDE_W'(rate_ff) + WIDE_W'(step_delta));
   assign angle_sum   = WIDE_W'(angle_ff) + WIDE_W'(step_delta);

   // limit check, upper bound first
   always_comb begin
      limit_in = 1'b0;
      angle_in = signed'(angle_sum[ANGLE_W-1:0]);
      if (angle_sum > WIDE_W'(max_angle_ff)) begin
         angle_in = max_angle_ff;
         limit_in = 1'b1;
      end else if (angle_sum < WIDE_W'(min_angle_ff)) begin
         angle_in = min_angle_ff;
         limit_in = 1'b1;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (advance) begin
         if (uw.mul_en) begin
            prod_ff <= mul_p;
         end
         if (uw.sin_ld) begin
            sin_ff <= SINE_ROM[sin_idx];
         end
         if (uw.acc_ld) begin
            acc_ff <= prod_ff;
         end
      end
   end

   // model state
   always_ff @(posedge clock) begin
      if (reset) begin
         angle_ff  <= '0;
         rate_ff   <= '0;
         accel_ff  <= '0;
         thrust_ff <= '0;
      end else if (advance) begin
         if (uw.accel_wr) begin
            accel_ff  <= accel_in;
            thrust_ff <= item_thrust_ff;
         end
         if (uw.rate_wr) begin
            rate_ff <= rate_in;
         end
         if (uw.fin_step) begin
            angle_ff <= angle_in;
            if (limit_in) begin
               rate_ff <= '0;
            end
         end
         if (uw.fin_set) begin
            angle_ff <= item_angle_ff;
         end
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && fin) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && fin) begin
         rsp_accel_ff       <= accel_ff;
         rsp_last_thrust_ff <= thrust_ff;
         if (uw.fin_step) begin
            rsp_angle_ff    <= angle_in;
            rsp_rate_ff     <= limit_in ? '0 : rate_ff;
            rsp_at_limit_ff <= limit_in;
         end else begin
            rsp_angle_ff    <= item_angle_ff;
            rsp_rate_ff     <= rate_ff;
            rsp_at_limit_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_angle       = rsp_angle_ff;
   assign rsp_rate        = rsp_rate_ff;
   assign rsp_accel       = rsp_accel_ff;
   assign rsp_last_thrust = rsp_last_thrust_ff;
   assign rsp_at_limit    = rsp_at_limit_ff;

endmodule

### hw/rtl/pae_step_checker.sv
// port-level checks for the pendulum arm step unit, bound to the top level
// depends on: pae_pkg, pendulum_arm_euler_step_unit_defines.svh
`timescale 1ns / 1ps
`include "pendulum_arm_euler_step_unit_defines.svh"

module pae_step_checker
   import pae_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic signed [DATA_W-1:0] rsp_rate,
   input logic                     rsp_at_limit
);

   logic [1:0] pend_ff;
   logic [1:0] pend_in;
   logic       req_xfer;
   logic       rsp_xfer;

   // requests taken but not yet answered
   assign req_xfer = req_valid & req_ready;
   assign rsp_xfer = rsp_valid & rsp_ready;
   assign pend_in  = 2'(pend_ff + 2'(req_xfer) - 2'(rsp_xfer));

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   // no response without an outstanding request
   `PAE_ASSERT_IMPLY(a_rsp_has_req, rsp_valid, pend_ff != 2'd0)
   // at most one request in work and one answered
   `PAE_ASSERT_ALWAYS(a_pend_bound, pend_ff != 2'd3)
   // the unit is busy right after a request transfer
   `PAE_ASSERT_NEXT(a_busy_after_req, req_xfer, !req_ready)
   // a clamped step reports a zero rate
   `PAE_ASSERT_IMPLY(a_limit_zero_rate, rsp_valid && rsp_at_limit, rsp_rate == '0)

endmodule

bind pendulum_arm_euler_step_unit pae_step_checker u_pae_step_checker (.*);
